### hdl/npm_pkg.sv
package npm_pkg;

   localparam int NUM_COEFFS = 256;
   localparam int Q_BITS     = 14;
   localparam int IDX_BITS   = $clog2(NUM_COEFFS);
   localparam int CMD_BITS   = 2;
   localparam int INDEX_BITS = 8;
   localparam int OPND_BITS  = 16;
   localparam int COEF_BITS  = 14;
   localparam int DRAIN_CYCLES = 3;
   localparam int DRAIN_BITS = $clog2(DRAIN_CYCLES + 1);

   localparam logic [CMD_BITS-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_COMPUTE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                load_en;
      logic                read_en;
      logic                mac_en;
      logic                neg;
      logic                first;
      logic                last;
      logic [IDX_BITS-1:0] i;
      logic [IDX_BITS-1:0] j;
      logic [IDX_BITS-1:0] k;
   } ctrl_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

endpackage

### hdl/npm_ctrl.sv
module npm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [npm_pkg::CMD_BITS-1:0]  req_cmd,
   input  logic [npm_pkg::INDEX_BITS-1:0] req_index,
   output logic                          req_stall,
   input  npm_pkg::status_type           status,
   output npm_pkg::ctrl_type             ctrl
);
   import npm_pkg::*;

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   i_ff, i_in;
   logic [IDX_BITS-1:0]   k_ff, k_in;
   logic [DRAIN_BITS-1:0] drain_ff, drain_in;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         k_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         drain_ff <= drain_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      drain_in  = drain_ff;
      req_stall = 1'b1;
      accept    = 1'b0;
      ctrl      = '0;
      ctrl.i    = i_ff;
      ctrl.k    = k_ff;
      ctrl.j    = k_ff - i_ff;
      ctrl.neg  = (i_ff > k_ff);
      ctrl.first = (i_ff == '0);
      ctrl.last  = (i_ff == IDX_BITS'(NUM_COEFFS - 1));
      case (state_ff)
         ST_IDLE: begin
            // A read must wait while the previous result is still held.
            req_stall = (req_cmd == CMD_READ) && status.rsp_busy;
            accept    = req_valid && !req_stall;
            if (accept) begin
               case (req_cmd)
                  CMD_LOAD: begin
                     ctrl.load_en = ({1'b0, req_index} < (INDEX_BITS+1)'(NUM_COEFFS));
                  end
                  CMD_COMPUTE: begin
                     state_in = ST_MAC;
                     i_in     = '0;
                     k_in     = '0;
                  end
                  CMD_READ: begin
                     ctrl.read_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            ctrl.mac_en = 1'b1;
            if (ctrl.last) begin
               i_in = '0;
               if (k_ff == IDX_BITS'(NUM_COEFFS - 1)) begin
                  state_in = ST_DRAIN;
                  drain_in = '0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // Let the last sums leave the multiply pipeline before new requests.
            drain_in = drain_ff + 1'b1;
            if (drain_ff == DRAIN_BITS'(DRAIN_CYCLES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/npm_dp.sv
module npm_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  npm_pkg::ctrl_type              ctrl,
   input  logic [npm_pkg::INDEX_BITS-1:0] req_index,
   input  logic [npm_pkg::OPND_BITS-1:0]  req_a_coef,
   input  logic [npm_pkg::OPND_BITS-1:0]  req_b_coef,
   output npm_pkg::status_type            status,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [npm_pkg::COEF_BITS-1:0]  rsp_coef
);
   import npm_pkg::*;

   logic [OPND_BITS-1:0] mem_a [NUM_COEFFS];
   logic [OPND_BITS-1:0] mem_b [NUM_COEFFS];
   logic [Q_BITS-1:0]    mem_p [NUM_COEFFS];

   logic [OPND_BITS-1:0] a_rd_ff, b_rd_ff;
   logic                 s1_valid_ff, s1_neg_ff, s1_first_ff, s1_last_ff;
   logic [IDX_BITS-1:0]  s1_k_ff;
   logic [Q_BITS-1:0]    prod_ff;
   logic [2*Q_BITS-1:0]  full_prod;
   logic                 s2_valid_ff, s2_neg_ff, s2_first_ff, s2_last_ff;
   logic [IDX_BITS-1:0]  s2_k_ff;
   logic [Q_BITS-1:0]    acc_ff, acc_in, acc_base;
   logic [Q_BITS-1:0]    rd_data_ff;
   logic                 rd_range_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 in_range;

   assign in_range = ({1'b0, req_index} < (INDEX_BITS+1)'(NUM_COEFFS));

   always_ff @(posedge clock) begin
      if (ctrl.load_en) begin
         mem_a[req_index[IDX_BITS-1:0]] <= req_a_coef;
         mem_b[req_index[IDX_BITS-1:0]] <= req_b_coef;
      end
      a_rd_ff <= mem_a[ctrl.i];
      b_rd_ff <= mem_b[ctrl.j];
   end

   always_ff @(posedge clock) begin
      if (ctrl.read_en) begin
         rd_data_ff  <= mem_p[req_index[IDX_BITS-1:0]];
         rd_range_ff <= in_range;
      end
      if (s2_valid_ff && s2_last_ff) begin
         mem_p[s2_k_ff] <= acc_in;
      end
   end

   // Only the low Q_BITS of each term matter since q divides the accumulator range.
   assign full_prod = a_rd_ff[Q_BITS-1:0] * b_rd_ff[Q_BITS-1:0];
   assign acc_base  = s2_first_ff ? '0 : acc_ff;
   assign acc_in    = s2_neg_ff ? (acc_base - prod_ff) : (acc_base + prod_ff);

   always_ff @(posedge clock) begin
      prod_ff     <= full_prod[Q_BITS-1:0];
      s1_neg_ff   <= ctrl.neg;
      s1_first_ff <= ctrl.first;
      s1_last_ff  <= ctrl.last;
      s1_k_ff     <= ctrl.k;
      s2_neg_ff   <= s1_neg_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_k_ff     <= s1_k_ff;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= ctrl.mac_en;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.read_en) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_coef  = rd_range_ff ? COEF_BITS'(rd_data_ff) : '0;

endmodule

### hdl/negacyclic_poly_multiplier.sv
// Multiplies two polynomials of NUM_COEFFS coefficients modulo X^N+1 and q = 2^Q_BITS.
// A load request writes both operand coefficients at one index. A read request returns
// one result coefficient in the cycle after acceptance. A compute request runs a single
// multiply-accumulate unit over every pair of operand coefficients, fed by one read port
// on each operand memory, and occupies the block until the last sums have been written
// back, during which no request is accepted. NUM_COEFFS must be a power of two.
module negacyclic_poly_multiplier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [npm_pkg::CMD_BITS-1:0]   req_cmd,
   input  logic [npm_pkg::INDEX_BITS-1:0] req_index,
   input  logic [npm_pkg::OPND_BITS-1:0]  req_a_coef,
   input  logic [npm_pkg::OPND_BITS-1:0]  req_b_coef,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [npm_pkg::COEF_BITS-1:0]  rsp_coef
);
   import npm_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   npm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_index (req_index),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   npm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_index  (req_index),
      .req_a_coef (req_a_coef),
      .req_b_coef (req_b_coef),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_coef   (rsp_coef)
   );

endmodule
